### design/urtrb_pkg.sv
// ----------------------------------------------------------------------------
// urtrb_pkg
// shared types, command codes and port layout for the uart ring buffer block
// ----------------------------------------------------------------------------
package urtrb_pkg;

   // event codes carried on req_tuser
   localparam logic [1:0] CMD_RX_BYTE   = 2'd0;
   localparam logic [1:0] CMD_TX_DONE   = 2'd1;
   localparam logic [1:0] CMD_HOST_PUT  = 2'd2;
   localparam logic [1:0] CMD_HOST_GET  = 2'd3;

   localparam int CMD_W        = 2;
   localparam int DATA_W       = 8;
   localparam int ERR_W        = 3;
   localparam int RX_LEVEL_W   = 6;
   localparam int TX_LEVEL_W   = 7;

   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_FIELDS_W = 34;
   localparam int RSP_TDATA_W  = 40;

   localparam int DEFAULT_RX_DEPTH = 64;
   localparam int DEFAULT_TX_DEPTH = 64;

   // per-cycle strobes into one ring memory
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

### design/urtrb_mem.sv
// ----------------------------------------------------------------------------
// urtrb_mem
// byte-wide ring storage, one write and one registered read port
// ----------------------------------------------------------------------------
module urtrb_mem
   import urtrb_pkg::*;
#(
   parameter int DEPTH = DEFAULT_RX_DEPTH,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/urtrb_ctrl.sv
// ----------------------------------------------------------------------------
// urtrb_ctrl
// pointers, counts, driver enable and result register for both rings
// ----------------------------------------------------------------------------
module urtrb_ctrl
   import urtrb_pkg::*;
#(
   parameter int RX_DEPTH = DEFAULT_RX_DEPTH,
   parameter int TX_DEPTH = DEFAULT_TX_DEPTH,
   localparam int RX_AW   = $clog2(RX_DEPTH),
   localparam int TX_AW   = $clog2(TX_DEPTH),
   localparam int TX_CW   = $clog2(TX_DEPTH + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CMD_W-1:0]       cmd,
   input  logic [DATA_W-1:0]      data,
   input  logic [ERR_W-1:0]       rx_errors,
   input  logic                   tx_reg_empty,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output mem_ctl_type            rx_ctl,
   output logic [RX_AW-1:0]       rx_wr_addr,
   output logic [RX_AW-1:0]       rx_rd_addr,
   input  logic [DATA_W-1:0]      rx_rd_data,
   output mem_ctl_type            tx_ctl,
   output logic [TX_AW-1:0]       tx_wr_addr,
   output logic [TX_AW-1:0]       tx_rd_addr,
   input  logic [DATA_W-1:0]      tx_rd_data
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_READ = 1'b1;

   logic [0:0]             state_ff, state_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                   pend_rx_ff, pend_rx_in;

   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_AW-1:0] rx_count_ff, rx_count_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_CW-1:0] tx_count_ff, tx_count_in;
   logic             overflow_ff, overflow_in;
   logic             enable_ff, enable_in;

   logic             accept;
   logic             load;
   logic [RX_AW:0]   rx_count_inc;
   logic [RX_AW-1:0] rx_head_nx, rx_tail_nx;
   logic [TX_AW-1:0] tx_head_nx, tx_tail_nx;
   logic [31:0]      rx_count_wide, tx_count_wide;

   logic [DATA_W-1:0] read_byte, send_byte;
   logic              read_valid, send_valid, put_refused;

   assign req_tready = (state_ff == S_IDLE) && (!rsp_tvalid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign rx_count_inc = {1'b0, rx_count_ff} + (RX_AW + 1)'(1);
   assign rx_head_nx = (rx_head_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_ff + RX_AW'(1);
   assign rx_tail_nx = (rx_tail_ff == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_ff + RX_AW'(1);
   assign tx_head_nx = (tx_head_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_ff + TX_AW'(1);
   assign tx_tail_nx = (tx_tail_ff == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_ff + TX_AW'(1);

   assign rx_wr_addr = rx_head_ff;
   assign rx_rd_addr = rx_tail_ff;
   assign tx_wr_addr = tx_head_ff;
   assign tx_rd_addr = tx_tail_ff;

   always_comb begin
      state_in    = state_ff;
      pend_rx_in  = pend_rx_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      rx_count_in = rx_count_ff;
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      tx_count_in = tx_count_ff;
      overflow_in = overflow_ff;
      enable_in   = enable_ff;
      rx_ctl      = '0;
      tx_ctl      = '0;
      load        = 1'b0;
      read_byte   = '0;
      read_valid  = 1'b0;
      send_byte   = '0;
      send_valid  = 1'b0;
      put_refused = 1'b0;

      if (accept) begin
         load = 1'b1;
         unique case (cmd)
            CMD_RX_BYTE: begin
               if (rx_errors == '0) begin
                  rx_ctl.wr_en = 1'b1;
                  rx_head_in   = rx_head_nx;
                  // wrap of the count marks an overflow, queued bytes are lost
                  if (rx_count_inc == (RX_AW + 1)'(RX_DEPTH)) begin
                     rx_count_in = '0;
                     overflow_in = 1'b1;
                  end else begin
                     rx_count_in = rx_count_inc[RX_AW-1:0];
                  end
               end
            end
            CMD_TX_DONE: begin
               if (tx_count_ff != '0) begin
                  tx_ctl.rd_en = 1'b1;
                  tx_tail_in   = tx_tail_nx;
                  tx_count_in  = tx_count_ff - TX_CW'(1);
                  pend_rx_in   = 1'b0;
                  state_in     = S_READ;
                  load         = 1'b0;
               end else begin
                  enable_in = 1'b0;
               end
            end
            CMD_HOST_PUT: begin
               if (tx_count_ff == TX_CW'(TX_DEPTH)) begin
                  put_refused = 1'b1;
               end else if (tx_count_ff != '0 || !tx_reg_empty) begin
                  tx_ctl.wr_en = 1'b1;
                  tx_head_in   = tx_head_nx;
                  tx_count_in  = tx_count_ff + TX_CW'(1);
               end else begin
                  // idle transmitter: byte bypasses the ring
                  enable_in  = 1'b1;
                  send_byte  = data;
                  send_valid = 1'b1;
               end
            end
            CMD_HOST_GET: begin
               if (rx_count_ff != '0) begin
                  rx_ctl.rd_en = 1'b1;
                  rx_tail_in   = rx_tail_nx;
                  rx_count_in  = rx_count_ff - RX_AW'(1);
                  pend_rx_in   = 1'b1;
                  state_in     = S_READ;
                  load         = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end else if (state_ff == S_READ) begin
         // memory data is back, finish the pending get or transmit
         load     = 1'b1;
         state_in = S_IDLE;
         if (pend_rx_ff) begin
            read_byte  = rx_rd_data;
            read_valid = 1'b1;
         end else begin
            send_byte  = tx_rd_data;
            send_valid = 1'b1;
         end
      end
   end

   assign rx_count_wide = 32'(rx_count_in);
   assign tx_count_wide = 32'(tx_count_in);

   assign rsp_tdata_in = {(RSP_TDATA_W - RSP_FIELDS_W)'(0),
                          tx_count_wide[TX_LEVEL_W-1:0],
                          rx_count_wide[RX_LEVEL_W-1:0],
                          put_refused, overflow_in, enable_in,
                          send_valid, send_byte, read_valid, read_byte};

   always_comb begin
      if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         rx_count_ff   <= '0;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         tx_count_ff   <= '0;
         overflow_ff   <= 1'b0;
         enable_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         rx_count_ff   <= rx_count_in;
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         tx_count_ff   <= tx_count_in;
         overflow_ff   <= overflow_in;
         enable_ff     <= enable_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_rx_ff <= pend_rx_in;
      if (load) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef SYNTH
   a_rx_count_range: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= RX_AW'(RX_DEPTH - 1))
      else $error("rx count beyond depth");

   a_tx_count_range: assert property (@(posedge clock) disable iff (reset)
      tx_count_ff <= TX_CW'(TX_DEPTH))
      else $error("tx count beyond depth");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !rsp_tvalid_ff)
      else $error("result register busy while memory read outstanding");

   a_get_reads: assert property (@(posedge clock) disable iff (reset)
      accept && cmd == CMD_HOST_GET && rx_count_ff != '0 |=> state_ff == S_READ)
      else $error("get on non-empty ring did not issue a read");

   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |=> rsp_tvalid_ff && state_ff == S_IDLE)
      else $error("pending read did not produce a result");
`endif

endmodule

### design/uart_rx_tx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// receive and transmit byte rings between a uart and its host
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one event per item: the event code on req_tuser
//   (received byte, transmit complete, host put, host get) and the byte,
//   error bits and transmit-register-empty flag on req_tdata
//   rsp channel returns exactly one status item per request item: byte read
//   for the host, byte sent to the transmitter, driver enable, overflow,
//   put refusal and both ring levels after the event
// timing:
//   received byte, put and empty-ring events: result registered in the cycle
//   after accept, one item per cycle while rsp drains
//   get or transmit complete that pulls a byte from a ring: the result is
//   loaded from the registered read data of the ring memory; no new item is
//   taken while that read is outstanding
// reset:
//   pointers, counts, overflow and driver enable clear synchronously; ring
//   contents are not cleared, an entry is only read after being written
// backpressure:
//   a waiting result holds rsp_tdata; req_tready drops until it is taken
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers
   import urtrb_pkg::*;
#(
   parameter int RX_DEPTH = DEFAULT_RX_DEPTH,
   parameter int TX_DEPTH = DEFAULT_TX_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // data[7:0], rx_errors[10:8], tx_reg_empty[11], zero[15:12]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_byte[7:0], read_valid[8], send_byte[16:9], send_valid[17],
   // driver_enable[18], rx_overflow[19], put_refused[20], rx_level[26:21],
   // tx_level[33:27], zero[39:34]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);

   logic [DATA_W-1:0] data;
   logic [ERR_W-1:0]  rx_errors;
   logic              tx_reg_empty;

   mem_ctl_type       rx_ctl, tx_ctl;
   logic [RX_AW-1:0]  rx_wr_addr, rx_rd_addr;
   logic [TX_AW-1:0]  tx_wr_addr, tx_rd_addr;
   logic [DATA_W-1:0] rx_rd_data, tx_rd_data;

   // unpack request fields
   assign data         = req_tdata[DATA_W-1:0];
   assign rx_errors    = req_tdata[DATA_W+ERR_W-1:DATA_W];
   assign tx_reg_empty = req_tdata[DATA_W+ERR_W];

   urtrb_ctrl #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .cmd          (req_tuser),
      .data         (data),
      .rx_errors    (rx_errors),
      .tx_reg_empty (tx_reg_empty),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rx_ctl       (rx_ctl),
      .rx_wr_addr   (rx_wr_addr),
      .rx_rd_addr   (rx_rd_addr),
      .rx_rd_data   (rx_rd_data),
      .tx_ctl       (tx_ctl),
      .tx_wr_addr   (tx_wr_addr),
      .tx_rd_addr   (tx_rd_addr),
      .tx_rd_data   (tx_rd_data)
   );

   // receive ring, written by good received bytes, read by host gets
   urtrb_mem #(
      .DEPTH (RX_DEPTH)
   ) u_rx_mem (
      .clock   (clock),
      .ctl     (rx_ctl),
      .wr_addr (rx_wr_addr),
      .wr_data (data),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   // transmit ring, written by queued puts, read on transmit complete
   urtrb_mem #(
      .DEPTH (TX_DEPTH)
   ) u_tx_mem (
      .clock   (clock),
      .ctl     (tx_ctl),
      .wr_addr (tx_wr_addr),
      .wr_data (data),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

endmodule
